### design/bsr_pkg.sv
// Shared types and constants of the brush stroke rasterizer.
// Holds the event and pixel transaction structs, mode and register codes.
// No dependencies.
package bsr_pkg;

  localparam int unsigned DEFAULT_MAX_DIM = 2048;

  localparam int unsigned COORD_W = 12;  // event coordinates, two's complement
  localparam int unsigned PIX_W   = 11;  // output pixel coordinates
  localparam int unsigned RAD_W   = 8;
  localparam int unsigned DIM_CFG_W = 12;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned CFG_W   = 32;  // widest register
  localparam int unsigned BOX_W   = 14;  // signed box bounds and scan position
  localparam int unsigned ERR_W   = 15;  // signed doubled line error

  localparam logic [RAD_W-1:0]     RADIUS_RST = 8'd4;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [COLOR_W-1:0]   COLOR_RST  = 32'hFF00_0000;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_PRESS   = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_MOVE    = 3'd3,
    MODE_LEAVE   = 3'd4,
    MODE_OTHER   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CFG_BRUSH_RADIUS  = 2'd0,
    CFG_CANVAS_WIDTH  = 2'd1,
    CFG_CANVAS_HEIGHT = 2'd2,
    CFG_DRAW_COLOR    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]                 mode;
    logic                       left_button;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
  } event_t;

  typedef struct packed {
    logic                write_enable;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last;
  } pixel_t;

endpackage

### design/brush_stroke_rasterizer.sv
// Brush stroke rasterizer top level: event decode, Bresenham stepper and disc scan.
// Depends on bsr_pkg.
//
// Press, release and move events set up a drawing, leave only ends the stroke; each tick
// transaction accepted while the block is busy yields one candidate pixel of
// the current disc, marked last on the final candidate of the drawing. Every
// transaction is taken and its result lands in the output register on the
// same edge, so one transaction per cycle is sustained; the input stalls only
// while the output register holds a result that the sink stalls. A disc of
// radius r costs one tick per pixel of its clipped box [c-r, c+r), one tick if
// the box is empty; a line of major length n stamps n discs. Events that
// arrive while busy are dropped, so the host waits for last before sending the
// next event. The host writes registers only while idle; the block does not check.
module brush_stroke_rasterizer
  import bsr_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  event_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pixel_t               out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  // configuration
  logic [RAD_W-1:0]     radius_q;
  logic [DIM_CFG_W-1:0] width_q, height_q;
  logic [COLOR_W-1:0]   color_q;

  // stroke and line state
  logic                        pressed_q, pressed_d;
  logic                        busy_q, busy_d;
  logic signed [COORD_W-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_W-1:0]   major_q, major_d, minor_q, minor_d;
  logic signed [COORD_W-1:0]   line_end_q, line_end_d;
  logic signed [ERR_W-1:0]     error_q, error_d;
  logic [COORD_W-1:0]          dx_q, dx_d, dy_q, dy_d;
  logic                        steep_q, steep_d, neg_q, neg_d, ln_active_q, ln_active_d;

  // disc state
  logic signed [COORD_W-1:0]   dc_x_q, dc_x_d, dc_y_q, dc_y_d;
  logic signed [BOX_W-1:0]     scan_x_q, scan_x_d, scan_y_q, scan_y_d;
  logic signed [BOX_W-1:0]     x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;

  // output register
  logic    out_valid_q;
  pixel_t  out_data_q;
  logic    res_valid;
  pixel_t  res;

  logic in_acc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  function automatic logic signed [BOX_W-1:0] box_lo(
    input logic signed [COORD_W-1:0] c,
    input logic [RAD_W-1:0]          r
  );
    logic signed [BOX_W-1:0] v;
    v = BOX_W'(c) - $signed(BOX_W'(r));
    return (v < 0) ? '0 : v;
  endfunction

  function automatic logic signed [BOX_W-1:0] box_hi(
    input logic signed [COORD_W-1:0] c,
    input logic [RAD_W-1:0]          r,
    input logic signed [BOX_W-1:0]   lim
  );
    logic signed [BOX_W-1:0] v;
    v = BOX_W'(c) + $signed(BOX_W'(r));
    return (v > lim) ? lim : v;
  endfunction

  // canvas size clipped to MAX_DIM
  logic [DIM_W-1:0]        w_dim, h_dim;
  logic signed [BOX_W-1:0] w_lim, h_lim;

  always_comb begin
    w_dim = ({1'b0, width_q} > (DIM_CFG_W+1)'(MAX_DIM))  ? DIM_W'(MAX_DIM) : DIM_W'(width_q);
    h_dim = ({1'b0, height_q} > (DIM_CFG_W+1)'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(height_q);
    w_lim = $signed(BOX_W'(w_dim));
    h_lim = $signed(BOX_W'(h_dim));
  end

  // line setup from the previous point to the event point
  logic signed [COORD_W:0]   ls_ddx, ls_ddy, ls_dxw, ls_dyw;
  logic [COORD_W:0]          ls_adx, ls_ady;
  logic                      ls_steep, ls_swap, ls_neg;
  logic signed [COORD_W-1:0] sa1, sb1, sa2, sb2, fa1, fb1, fa2, fb2;
  logic [COORD_W-1:0]        ls_dx, ls_dy;

  always_comb begin
    ls_ddx   = (COORD_W+1)'(in_data_i.pos_x) - (COORD_W+1)'(cur_x_q);
    ls_ddy   = (COORD_W+1)'(in_data_i.pos_y) - (COORD_W+1)'(cur_y_q);
    ls_adx   = (ls_ddx < 0) ? unsigned'(-ls_ddx) : unsigned'(ls_ddx);
    ls_ady   = (ls_ddy < 0) ? unsigned'(-ls_ddy) : unsigned'(ls_ddy);
    ls_steep = ls_ady > ls_adx;
    sa1 = ls_steep ? cur_y_q : cur_x_q;
    sb1 = ls_steep ? cur_x_q : cur_y_q;
    sa2 = ls_steep ? in_data_i.pos_y : in_data_i.pos_x;
    sb2 = ls_steep ? in_data_i.pos_x : in_data_i.pos_y;
    ls_swap = sa1 > sa2;
    fa1 = ls_swap ? sa2 : sa1;
    fb1 = ls_swap ? sb2 : sb1;
    fa2 = ls_swap ? sa1 : sa2;
    fb2 = ls_swap ? sb1 : sb2;
    ls_dxw = (COORD_W+1)'(fa2) - (COORD_W+1)'(fa1);
    ls_dyw = (COORD_W+1)'(fb2) - (COORD_W+1)'(fb1);
    ls_dx  = ls_dxw[COORD_W-1:0];
    ls_dy  = (ls_dyw < 0) ? COORD_W'(unsigned'(-ls_dyw)) : ls_dyw[COORD_W-1:0];
    ls_neg = !(fb1 < fb2);
  end

  // one Bresenham step
  logic signed [ERR_W-1:0]   st_err, st_err_adj;
  logic signed [COORD_W-1:0] st_minor, st_major;

  always_comb begin
    st_err   = error_q - $signed({2'b00, dy_q, 1'b0});
    st_major = major_q + 12'sd1;
    if (st_err < 0) begin
      st_err_adj = st_err + $signed({2'b00, dx_q, 1'b0});
      st_minor   = neg_q ? (minor_q - 12'sd1) : (minor_q + 12'sd1);
    end else begin
      st_err_adj = st_err;
      st_minor   = minor_q;
    end
  end

  // distance test of the current candidate; inside a box |d| <= r fits 9 bits
  logic signed [BOX_W-1:0]   dd_x, dd_y;
  logic signed [RAD_W:0]     ds_x, ds_y;
  logic signed [2*RAD_W+1:0] sq_x, sq_y;
  logic signed [2*RAD_W+2:0] dist2;
  logic [2*RAD_W-1:0]        rr;
  logic                      in_disc;

  always_comb begin
    dd_x    = BOX_W'(dc_x_q) - scan_x_q;
    dd_y    = BOX_W'(dc_y_q) - scan_y_q;
    ds_x    = dd_x[RAD_W:0];
    ds_y    = dd_y[RAD_W:0];
    sq_x    = ds_x * ds_x;
    sq_y    = ds_y * ds_y;
    dist2   = (2*RAD_W+3)'(sq_x) + (2*RAD_W+3)'(sq_y);
    rr      = radius_q * radius_q;
    in_disc = dist2 <= $signed({3'b000, rr});
  end

  // scan advance
  logic                    box_empty, scan_wrap, disc_done;
  logic signed [BOX_W-1:0] sx_inc, sx_nxt, sy_nxt;

  always_comb begin
    box_empty = (x0_q >= x1_q) || (y0_q >= y1_q);
    sx_inc    = scan_x_q + 14'sd1;
    scan_wrap = sx_inc >= x1_q;
    sx_nxt    = scan_wrap ? x0_q : sx_inc;
    sy_nxt    = scan_wrap ? (scan_y_q + 14'sd1) : scan_y_q;
    disc_done = box_empty || (sy_nxt >= y1_q);
  end

  // next state
  logic                      disc_load;
  logic signed [COORD_W-1:0] cen_x, cen_y;

  always_comb begin
    pressed_d   = pressed_q;
    busy_d      = busy_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    major_d     = major_q;
    minor_d     = minor_q;
    line_end_d  = line_end_q;
    error_d     = error_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    steep_d     = steep_q;
    neg_d       = neg_q;
    ln_active_d = ln_active_q;
    dc_x_d      = dc_x_q;
    dc_y_d      = dc_y_q;
    scan_x_d    = scan_x_q;
    scan_y_d    = scan_y_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    y0_d        = y0_q;
    y1_d        = y1_q;
    disc_load   = 1'b0;
    cen_x       = '0;
    cen_y       = '0;
    res_valid   = 1'b0;
    res         = '0;

    if (in_acc) begin
      if (in_data_i.mode != MODE_TICK) begin
        if (!busy_q) begin
          case (in_data_i.mode)
            MODE_PRESS: begin
              if (in_data_i.left_button) begin
                pressed_d   = 1'b1;
                cur_x_d     = in_data_i.pos_x;
                cur_y_d     = in_data_i.pos_y;
                ln_active_d = 1'b0;
                disc_load   = 1'b1;
                cen_x       = in_data_i.pos_x;
                cen_y       = in_data_i.pos_y;
                busy_d      = 1'b1;
              end
            end
            MODE_RELEASE, MODE_MOVE: begin
              if (pressed_q) begin
                if (in_data_i.mode == MODE_RELEASE) pressed_d = 1'b0;
                cur_x_d = in_data_i.pos_x;
                cur_y_d = in_data_i.pos_y;
                steep_d = ls_steep;
                dx_d    = ls_dx;
                dy_d    = ls_dy;
                // zero length line draws nothing
                if (ls_dx != '0) begin
                  error_d     = ERR_W'(ls_dx);
                  neg_d       = ls_neg;
                  major_d     = fa1;
                  minor_d     = fb1;
                  line_end_d  = fa2;
                  ln_active_d = 1'b1;
                  disc_load   = 1'b1;
                  cen_x       = ls_steep ? fb1 : fa1;
                  cen_y       = ls_steep ? fa1 : fb1;
                  busy_d      = 1'b1;
                end
              end
            end
            MODE_LEAVE: pressed_d = 1'b0;
            default: ;
          endcase
        end
      end else if (busy_q) begin
        res_valid        = 1'b1;
        res.pixel_color  = color_q;
        if (!box_empty) begin
          res.write_enable = in_disc;
          res.pixel_x      = scan_x_q[PIX_W-1:0];
          res.pixel_y      = scan_y_q[PIX_W-1:0];
          scan_x_d         = sx_nxt;
          scan_y_d         = sy_nxt;
        end
        if (disc_done) begin
          if (ln_active_q) begin
            error_d = st_err_adj;
            minor_d = st_minor;
            major_d = st_major;
            if (st_major >= line_end_q) begin
              ln_active_d = 1'b0;
              busy_d      = 1'b0;
              res.last    = 1'b1;
            end else begin
              disc_load = 1'b1;
              cen_x     = steep_q ? st_minor : st_major;
              cen_y     = steep_q ? st_major : st_minor;
            end
          end else begin
            busy_d   = 1'b0;
            res.last = 1'b1;
          end
        end
      end
    end

    if (disc_load) begin
      dc_x_d   = cen_x;
      dc_y_d   = cen_y;
      x0_d     = box_lo(cen_x, radius_q);
      x1_d     = box_hi(cen_x, radius_q, w_lim);
      y0_d     = box_lo(cen_y, radius_q);
      y1_d     = box_hi(cen_y, radius_q, h_lim);
      scan_x_d = box_lo(cen_x, radius_q);
      scan_y_d = box_lo(cen_y, radius_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RADIUS_RST;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      color_q     <= COLOR_RST;
      pressed_q   <= 1'b0;
      busy_q      <= 1'b0;
      cur_x_q     <= '1;
      cur_y_q     <= '1;
      major_q     <= '0;
      minor_q     <= '0;
      line_end_q  <= '0;
      error_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      steep_q     <= 1'b0;
      neg_q       <= 1'b0;
      ln_active_q <= 1'b0;
      dc_x_q      <= '0;
      dc_y_q      <= '0;
      scan_x_q    <= '0;
      scan_y_q    <= '0;
      x0_q        <= '0;
      x1_q        <= '0;
      y0_q        <= '0;
      y1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BRUSH_RADIUS:  radius_q <= cfg_data_i[RAD_W-1:0];
          CFG_CANVAS_WIDTH:  width_q  <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_CANVAS_HEIGHT: height_q <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_DRAW_COLOR:    color_q  <= cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      pressed_q   <= pressed_d;
      busy_q      <= busy_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      line_end_q  <= line_end_d;
      error_q     <= error_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      steep_q     <= steep_d;
      neg_q       <= neg_d;
      ln_active_q <= ln_active_d;
      dc_x_q      <= dc_x_d;
      dc_y_q      <= dc_y_d;
      scan_x_q    <= scan_x_d;
      scan_y_q    <= scan_y_d;
      x0_q        <= x0_d;
      x1_q        <= x1_d;
      y0_q        <= y0_d;
      y1_q        <= y1_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  // line stepping only happens inside a busy drawing
  a_active_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_active_q |-> busy_q)
    else $error("line active while idle");

  a_major_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_active_q |-> (major_q < line_end_q))
    else $error("line stepped past its end");

  a_scan_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !box_empty) |->
      (scan_x_q >= x0_q && scan_x_q < x1_q && scan_y_q >= y0_q && scan_y_q < y1_q))
    else $error("disc scan outside its box");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.last) |=> !busy_q)
    else $error("still busy after last candidate");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

endmodule
